>>> design/vertex_project_clip_bbox_unit_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the vertex projection unit
// Implication checks sampled on clk_i, off while rst_ni is low.
// ------------------------------------------------------------------------
`ifndef VERTEX_PROJECT_CLIP_BBOX_UNIT_MACROS_SVH
`define VERTEX_PROJECT_CLIP_BBOX_UNIT_MACROS_SVH

// same-cycle implication
`define VPCB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vpcb assertion failed");

// next-cycle implication
`define VPCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vpcb assertion failed");

`endif

>>> design/vpcb_pkg.sv
// ------------------------------------------------------------------------
// vpcb_pkg
// Constants and types shared by the projection unit and its divider.
// ------------------------------------------------------------------------
package vpcb_pkg;

  localparam int unsigned NUM_W   = 60;
  localparam int unsigned DEN_W   = 48;
  localparam int unsigned QUO_W   = 31;
  localparam int unsigned CFG_W   = 26;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0] Z_NEAR_PLANE    = 32'd327680;
  localparam logic [31:0] INV_DEPTH_SCALE = 32'd65536;
  localparam logic [9:0]  SCREEN_WIDTH    = 10'd256;
  localparam logic [9:0]  SCREEN_HEIGHT   = 10'd192;

  localparam logic [NUM_W-1:0] INV_NUM = {12'd0, INV_DEPTH_SCALE, 16'd0};
  localparam logic [30:0] INV_MAX = 31'h7FFF_FFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_R_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_R_RIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_R_BOTTOM = 3'd7;

  // clip flag bits
  localparam int unsigned FLAG_NEAR   = 0;
  localparam int unsigned FLAG_LEFT   = 1;
  localparam int unsigned FLAG_TOP    = 2;
  localparam int unsigned FLAG_RIGHT  = 3;
  localparam int unsigned FLAG_BOTTOM = 4;

  typedef struct packed {
    logic start;
    logic long_q;   // 1: 31 quotient bits, 0: 17 quotient bits
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic ovf;      // quotient does not fit the selected length
  } div_stat_t;

endpackage

>>> design/vertex_project_clip_bbox_unit.sv
// ------------------------------------------------------------------------
// vertex_project_clip_bbox_unit
// Perspective projection of one view-space vertex per item, clip outcodes
// and a running screen bounding box.
// ------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o   | view_x/y/z, last_vertex
// out     | output    | out_valid_o / out_ready_i | screen, inv_depth, flags, box
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A near-clipped vertex goes from the accept straight to the finish step.
// Any other vertex runs through the shared restoring divider once for 1/z
// (check, 31 steps, done) and once per screen axis (check, 17 steps, done),
// plus multiply/add steps on one shared 33x27 multiplier. in_ready_o is high
// only while the sequencer idles.
// The result sits in an output register; the next item is taken while it
// waits, and the finish step stalls only if the previous result is unread.
// Reset returns control, config and the box to their initial values.
// ------------------------------------------------------------------------
`include "vertex_project_clip_bbox_unit_macros.svh"

module vertex_project_clip_bbox_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config
  input  logic                           cfg_we_i,
  input  logic [vpcb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vpcb_pkg::CFG_W-1:0]     cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             view_x_i,
  input  logic signed [31:0]             view_y_i,
  input  logic signed [31:0]             view_z_i,
  input  logic                           last_vertex_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             screen_x_o,
  output logic signed [15:0]             screen_y_o,
  output logic [30:0]                    inv_depth_o,
  output logic [4:0]                     clip_flags_o,
  output logic [9:0]                     box_left_o,
  output logic [9:0]                     box_top_o,
  output logic [9:0]                     box_right_o,
  output logic [9:0]                     box_bottom_o,
  output logic signed [10:0]             box_width_o,
  output logic signed [10:0]             box_height_o,
  output logic                           final_res_o
);
  import vpcb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INV, S_INVW, S_MA, S_MB, S_MS, S_DIV, S_DIVW, S_FIN
  } state_e;

  state_e state_q;

  // config registers
  logic [23:0] x_scale_q, y_scale_q;
  logic [25:0] x_center_q, y_center_q;
  logic [9:0]  rect_left_q, rect_top_q, rect_right_q, rect_bottom_q;

  // running box
  logic [9:0]  acc_left_q, acc_top_q, acc_right_q, acc_bottom_q;

  // item working regs
  logic signed [31:0] vx_q, vy_q, vz_q;
  logic               last_q;
  logic               near_q;
  logic               axis_q;     // 0: x, 1: y
  logic [30:0]        inv_q;
  logic signed [15:0] sx_q, sy_q;
  logic signed [NUM_W-1:0] prod_q, sum_q;

  // outputs
  logic               out_valid_q;
  logic signed [15:0] scr_x_q, scr_y_q;
  logic [30:0]        inv_out_q;
  logic [4:0]         flags_q;
  logic [9:0]         bl_q, bt_q, br_q, bb_q;
  logic signed [10:0] bw_q, bh_q;
  logic               fin_q;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [NUM_W-1:0] mul_p;

  always_comb begin
    if (state_q == S_MA) begin
      mul_a = axis_q ? {vy_q[31], vy_q} : {vx_q[31], vx_q};
      mul_b = axis_q ? $signed({3'd0, y_scale_q}) : $signed({3'd0, x_scale_q});
    end else begin
      mul_a = {vz_q[31], vz_q};
      mul_b = axis_q ? $signed({1'b0, y_center_q}) : $signed({1'b0, x_center_q});
    end
    mul_p = mul_a * mul_b;
  end

  // shared divider
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [QUO_W-1:0]   div_quo;

  always_comb begin
    div_ctrl.start  = (state_q == S_INV) || (state_q == S_DIV);
    div_ctrl.long_q = (state_q == S_INV);
    if (state_q == S_INV) begin
      div_num = INV_NUM;
      div_den = {17'd0, vz_q[30:0]};
    end else begin
      div_num = sum_q[NUM_W-1] ? NUM_W'(-sum_q) : NUM_W'(sum_q);
      div_den = {vz_q, 16'd0};
    end
  end

  vpcb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // quotient to saturated 16-bit screen coordinate (toward zero)
  logic        neg_q;
  logic [16:0] q17;
  logic signed [15:0] sat;

  always_comb begin
    q17 = div_quo[16:0];
    if (!neg_q) begin
      sat = (div_stat.ovf || q17[16:15] != 2'd0) ? 16'sh7FFF : $signed(q17[15:0]);
    end else begin
      sat = (div_stat.ovf || q17 > 17'd32768) ? 16'sh8000
                                                : $signed(16'(~q17[15:0] + 16'd1));
    end
  end

  // clip test and box update
  logic signed [16:0] sxe, sye;
  logic [4:0] flags_n;
  logic [9:0] nl, nt, nr, nb;

  always_comb begin
    sxe = {sx_q[15], sx_q};
    sye = {sy_q[15], sy_q};
    flags_n = '0;
    nl = acc_left_q;
    nt = acc_top_q;
    nr = acc_right_q;
    nb = acc_bottom_q;
    if (near_q) begin
      flags_n[FLAG_NEAR] = 1'b1;
    end else begin
      if (sxe < $signed({7'd0, rect_left_q})) begin
        flags_n[FLAG_LEFT] = 1'b1;
        nl = rect_left_q;
      end else if (sxe < $signed({7'd0, acc_left_q})) begin
        nl = sx_q[9:0];
      end
      if (sye < $signed({7'd0, rect_top_q})) begin
        flags_n[FLAG_TOP] = 1'b1;
        nt = rect_top_q;
      end else if (sye < $signed({7'd0, acc_top_q})) begin
        nt = sy_q[9:0];
      end
      if (sxe > $signed({7'd0, rect_right_q})) begin
        flags_n[FLAG_RIGHT] = 1'b1;
        nr = rect_right_q;
      end else if (sxe > $signed({7'd0, acc_right_q})) begin
        nr = sx_q[9:0];
      end
      if (sye > $signed({7'd0, rect_bottom_q})) begin
        flags_n[FLAG_BOTTOM] = 1'b1;
        nb = rect_bottom_q;
      end else if (sye > $signed({7'd0, acc_bottom_q})) begin
        nb = sy_q[9:0];
      end
    end
  end

  logic in_fire, out_free;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      x_scale_q    <= 24'd65536;
      y_scale_q    <= 24'd65536;
      x_center_q   <= 26'd8388608;
      y_center_q   <= 26'd6291456;
      rect_left_q  <= 10'd0;
      rect_top_q   <= 10'd0;
      rect_right_q <= 10'd255;
      rect_bottom_q <= 10'd191;
      acc_left_q   <= SCREEN_WIDTH;
      acc_top_q    <= SCREEN_HEIGHT;
      acc_right_q  <= 10'd0;
      acc_bottom_q <= 10'd0;
      out_valid_q  <= 1'b0;
      axis_q       <= 1'b0;
      near_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_X_SCALE:  x_scale_q     <= cfg_data_i[23:0];
          REG_Y_SCALE:  y_scale_q     <= cfg_data_i[23:0];
          REG_X_CENTER: x_center_q    <= cfg_data_i;
          REG_Y_CENTER: y_center_q    <= cfg_data_i;
          REG_R_LEFT:   rect_left_q   <= cfg_data_i[9:0];
          REG_R_TOP:    rect_top_q    <= cfg_data_i[9:0];
          REG_R_RIGHT:  rect_right_q  <= cfg_data_i[9:0];
          REG_R_BOTTOM: rect_bottom_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end

      // the finish step reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            vx_q   <= view_x_i;
            vy_q   <= view_y_i;
            vz_q   <= view_z_i;
            last_q <= last_vertex_i;
            axis_q <= 1'b0;
            sx_q   <= '0;
            sy_q   <= '0;
            inv_q  <= '0;
            near_q <= view_z_i < $signed(Z_NEAR_PLANE);
            state_q <= (view_z_i < $signed(Z_NEAR_PLANE)) ? S_FIN : S_INV;
          end
        end
        S_INV: state_q <= S_INVW;
        S_INVW: begin
          if (div_stat.done) begin
            inv_q   <= div_stat.ovf ? INV_MAX : div_quo;
            state_q <= S_MA;
          end
        end
        S_MA: begin
          prod_q  <= mul_p;
          state_q <= S_MB;
        end
        S_MB: begin
          sum_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= S_MS;
        end
        S_MS: begin
          sum_q   <= sum_q + prod_q;
          state_q <= S_DIV;
        end
        S_DIV: begin
          neg_q   <= sum_q[NUM_W-1];
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_stat.done) begin
            if (axis_q) begin
              sy_q    <= sat;
              state_q <= S_FIN;
            end else begin
              sx_q    <= sat;
              axis_q  <= 1'b1;
              state_q <= S_MA;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            scr_x_q   <= sx_q;
            scr_y_q   <= sy_q;
            inv_out_q <= inv_q;
            flags_q   <= flags_n;
            bl_q      <= nl;
            bt_q      <= nt;
            br_q      <= nr;
            bb_q      <= nb;
            bw_q      <= $signed({1'b0, nr}) - $signed({1'b0, nl});
            bh_q      <= $signed({1'b0, nb}) - $signed({1'b0, nt});
            fin_q     <= last_q;
            if (last_q) begin
              acc_left_q   <= SCREEN_WIDTH;
              acc_top_q    <= SCREEN_HEIGHT;
              acc_right_q  <= 10'd0;
              acc_bottom_q <= 10'd0;
            end else begin
              acc_left_q   <= nl;
              acc_top_q    <= nt;
              acc_right_q  <= nr;
              acc_bottom_q <= nb;
            end
            state_q <= S_IDLE;
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign screen_x_o   = scr_x_q;
  assign screen_y_o   = scr_y_q;
  assign inv_depth_o  = inv_out_q;
  assign clip_flags_o = flags_q;
  assign box_left_o   = bl_q;
  assign box_top_o    = bt_q;
  assign box_right_o  = br_q;
  assign box_bottom_o = bb_q;
  assign box_width_o  = bw_q;
  assign box_height_o = bh_q;
  assign final_res_o  = fin_q;

  `VPCB_ASSERT_IMPL(a_div_done_waited, div_stat.done, (state_q == S_INVW) || (state_q == S_DIVW))
  `VPCB_ASSERT_NEXT(a_accept_busy, in_fire, !in_ready_o)
  `VPCB_ASSERT_IMPL(a_near_zero, out_valid_o && clip_flags_o[FLAG_NEAR], (screen_x_o == 16'sd0) && (inv_depth_o == 31'd0))
  `VPCB_ASSERT_NEXT(a_fin_loads, (state_q == S_FIN) && out_free, out_valid_o && in_ready_o)

endmodule

>>> design/vpcb_div.sv
// ------------------------------------------------------------------------
// vpcb_div
// Radix-2 restoring divider, one quotient bit per cycle, with overflow check.
// ------------------------------------------------------------------------
module vpcb_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vpcb_pkg::div_ctrl_t        ctrl_i,
  input  logic [vpcb_pkg::NUM_W-1:0] num_i,
  input  logic [vpcb_pkg::DEN_W-1:0] den_i,
  output vpcb_pkg::div_stat_t        stat_o,
  output logic [vpcb_pkg::QUO_W-1:0] quo_o
);
  import vpcb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHK, S_STEP, S_DONE} state_e;

  state_e            state_q;
  logic [NUM_W-1:0]  n_q;
  logic [DEN_W-1:0]  d_q;
  logic [DEN_W-1:0]  rem_q;
  logic [QUO_W-1:0]  lo_q;
  logic [QUO_W-1:0]  q_q;
  logic [4:0]        cnt_q;
  logic              long_q;
  logic              ovf_q;

  logic [NUM_W-1:0]  hi;
  logic [DEN_W:0]    trial;
  logic              fits;

  always_comb begin
    hi    = long_q ? (n_q >> 31) : (n_q >> 17);
    trial = {rem_q, lo_q[QUO_W-1]};
    fits  = trial >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      long_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (ctrl_i.start) begin
            n_q     <= num_i;
            d_q     <= den_i;
            long_q  <= ctrl_i.long_q;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          ovf_q <= hi >= NUM_W'(d_q);
          rem_q <= hi[DEN_W-1:0];
          lo_q  <= long_q ? n_q[30:0] : {n_q[16:0], 14'd0};
          cnt_q <= long_q ? 5'd31 : 5'd17;
          q_q   <= '0;
          state_q <= (hi >= NUM_W'(d_q)) ? S_DONE : S_STEP;
        end
        S_STEP: begin
          rem_q <= fits ? trial[DEN_W-1:0] - d_q : trial[DEN_W-1:0];
          q_q   <= {q_q[QUO_W-2:0], fits};
          lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd1) state_q <= S_DONE;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign stat_o.done = (state_q == S_DONE);
  assign stat_o.ovf  = ovf_q;
  assign quo_o       = q_q;

endmodule
